// File: hdl/batch_median_select_macros.svh
// Assertion macros used by the batch median top level.
`ifndef BATCH_MEDIAN_SELECT_MACROS_SVH
`define BATCH_MEDIAN_SELECT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define BMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bms_pkg.sv
// Package with the shared types and constants of the batch median block.
package bms_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned OUT_COUNT_W     = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // What one cell hands to the next one up the chain.
  typedef struct packed {
    logic    take;
    sample_t value;
  } bms_link_t;

endpackage

// File: hdl/bms_if.sv
// Stream interfaces for the sample words and the result words.
interface bms_in_if
  import bms_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface bms_out_if
  import bms_pkg::*;
();
  logic                   valid;
  logic                   ready;
  sample_t                median_value;
  logic [OUT_COUNT_W-1:0] sample_count;
  logic                   batch_empty;
  logic                   batch_overflow;

  modport source (output valid, output median_value, output sample_count,
                  output batch_empty, output batch_overflow, input ready);
  modport sink   (input valid, input median_value, input sample_count,
                  input batch_empty, input batch_overflow, output ready);
endinterface

// File: hdl/batch_median_select.sv
// Top level of the batch median block: cell chain, median pick and result register.
//
// Usage. Sample words arrive on in_i (valid/ready); each carries one signed
// Q16.16 value and a last_sample mark. Every word is placed into a chain of
// MAX_SAMPLES cells that keeps the batch in ascending order; a word that finds
// the chain full is dropped and the batch is flagged as overflowed.
// The word marked last closes the batch. Its own value is kept first if it fits, and one
// result word follows on out_o: the median, the number of values kept, an empty
// flag and the overflow flag. For an even count the median is the sum of the two
// middle values shifted right by one, rounding toward minus infinity.
// Throughput: one sample word per cycle while a batch is open. After the last
// word the chain is read in the pick state and the median summed in the sum
// state, which waits until the output register is free; the steps are set by
// the one-hot pick across the cells and the 33-bit add that follows it.
// Stalls: the result sits in an output register; the next batch is taken in
// while it waits, but a further result waits until the previous one is taken.
// Reset clears the count, the overflow flag and the output valid; the stored
// values need no clearing since only kept entries reach the result.
`include "batch_median_select_macros.svh"

module batch_median_select
  import bms_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bms_in_if.sink   in_i,
  bms_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CntW-1:0] CountMax = CntW'(MAX_SAMPLES);

  typedef enum logic [1:0] {
    S_COLLECT,
    S_PICK,
    S_SUM
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic                   dropped_q;
  sample_t                lo_q;
  sample_t                hi_q;
  logic                   out_valid_q;
  sample_t                out_median_q;
  logic [OUT_COUNT_W-1:0] out_count_q;
  logic                   out_empty_q;
  logic                   out_overflow_q;

  logic                   accept;
  logic                   has_room;
  logic                   insert;
  logic                   out_free;
  logic [CntW-1:0]        lo_idx;
  logic [CntW-1:0]        hi_idx;
  logic [SAMPLE_W:0]      pair_sum;
  sample_t                pick_lo;
  sample_t                pick_hi;

  bms_link_t              link   [MAX_SAMPLES];
  sample_t                cell_lo[MAX_SAMPLES];
  sample_t                cell_hi[MAX_SAMPLES];

  assign in_i.ready = (state_q == S_COLLECT);
  assign accept     = in_i.valid && in_i.ready;
  assign has_room   = (count_q < CountMax);
  assign insert     = accept && has_room;
  assign out_free   = !out_valid_q || out_o.ready;

  // Lower and upper middle positions; they coincide for an odd count.
  assign lo_idx = (count_q - CntW'(1)) >> 1;
  assign hi_idx = count_q >> 1;

  // The chain: each cell sees the take decision and value of the cell below.
  for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
    bms_link_t prev;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = link[g-1];
    end

    bms_cell #(
      .CNT_W (CntW),
      .IDX   (g)
    ) u_cell (
      .clk_i    (clk_i),
      .insert_i (insert),
      .sample_i (in_i.sample),
      .count_i  (count_q),
      .lo_idx_i (lo_idx),
      .hi_idx_i (hi_idx),
      .prev_i   (prev),
      .link_o   (link[g]),
      .lo_o     (cell_lo[g]),
      .hi_o     (cell_hi[g])
    );
  end

  // Only the addressed cell drives a non-zero value, so an OR gathers it.
  always_comb begin
    pick_lo = '0;
    pick_hi = '0;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      pick_lo = pick_lo | cell_lo[i];
      pick_hi = pick_hi | cell_hi[i];
    end
  end

  assign pair_sum = {lo_q[SAMPLE_W-1], lo_q} + {hi_q[SAMPLE_W-1], hi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_COLLECT;
      count_q        <= '0;
      dropped_q      <= 1'b0;
      lo_q           <= '0;
      hi_q           <= '0;
      out_valid_q    <= 1'b0;
      out_median_q   <= '0;
      out_count_q    <= '0;
      out_empty_q    <= 1'b0;
      out_overflow_q <= 1'b0;
    end else begin
      // A taken result word leaves, unless the sum step loads the next one in its place.
      if (out_valid_q && out_o.ready && (state_q != S_SUM)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_COLLECT: begin
          if (accept) begin
            if (has_room) begin
              count_q <= count_q + CntW'(1);
            end else begin
              dropped_q <= 1'b1;
            end
            if (in_i.last_sample) begin
              state_q <= S_PICK;
            end
          end
        end
        S_PICK: begin
          lo_q    <= pick_lo;
          hi_q    <= pick_hi;
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_median_q   <= (count_q == '0) ? '0 : sample_t'(pair_sum[SAMPLE_W:1]);
            out_count_q    <= OUT_COUNT_W'(count_q);
            out_empty_q    <= (count_q == '0);
            out_overflow_q <= dropped_q;
            count_q        <= '0;
            dropped_q      <= 1'b0;
            state_q        <= S_COLLECT;
          end
        end
        default: begin
          state_q <= S_COLLECT;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.median_value   = out_median_q;
  assign out_o.sample_count   = out_count_q;
  assign out_o.batch_empty    = out_empty_q;
  assign out_o.batch_overflow = out_overflow_q;

  `BMS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountMax, "kept count beyond store size")
  `BMS_ASSERT_NOW(a_drop_full, dropped_q, count_q == CountMax, "drop flagged with room left")
  `BMS_ASSERT_NEXT(a_last_closes, accept && in_i.last_sample, state_q == S_PICK, "batch not closed")
  `BMS_ASSERT_NEXT(a_count_step, insert && !in_i.last_sample, count_q == $past(count_q) + CntW'(1), "kept count did not advance")
  `BMS_ASSERT_NOW(a_load_in_sum, $rose(out_valid_q), $past(state_q) == S_SUM, "result loaded outside sum step")

endmodule

// File: hdl/bms_cell.sv
// One cell of the insertion-sort chain: holds one sorted entry.
module bms_cell
  import bms_pkg::*;
#(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  logic             insert_i,
  input  sample_t          sample_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CNT_W-1:0] lo_idx_i,
  input  logic [CNT_W-1:0] hi_idx_i,
  input  bms_link_t        prev_i,
  output bms_link_t        link_o,
  output sample_t          lo_o,
  output sample_t          hi_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  sample_t value_q;
  sample_t value_d;
  logic    take;

  // The cell is free, or holds a value that must move up past the new one.
  assign take = (MyIdx >= count_i) || (value_q > sample_i);

  always_comb begin
    value_d = value_q;
    if (insert_i && take) begin
      value_d = prev_i.take ? prev_i.value : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.take  = take;
  assign link_o.value = value_q;
  assign lo_o = (MyIdx == lo_idx_i) ? value_q : '0;
  assign hi_o = (MyIdx == hi_idx_i) ? value_q : '0;

endmodule

// File: bench/batch_median_select_test.sv
// Self-checking bench for batch_median_select: sorted-batch median against a queue predictor.
`timescale 1ns / 1ps

module batch_median_select_test
  import bms_pkg::*;
();

  // The store is left at its package default, so a batch keeps at most 64 values.
  localparam int unsigned STORE_DEPTH  = MAX_SAMPLES_DEF;
  localparam int unsigned RANDOM_WORDS = 700;
  localparam int unsigned DRAIN_CYCLES = 8;
  // The run sends under a thousand words, plus every gap and output stall.
  // The limit below is many times that.
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned REPORT_MAX   = 10;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // One result word as the block should give it.
  typedef struct packed {
    sample_t                median;
    logic [OUT_COUNT_W-1:0] count;
    logic                   empty;
    logic                   overflow;
  } median_result_t;

  logic clk_i;
  logic rst_ni;

  bms_in_if  in_if ();
  bms_out_if out_if ();

  batch_median_select #(
    .MAX_SAMPLES(STORE_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor state: the kept values of the open batch in ascending order, and
  // whether any value of it has been dropped for want of room.
  sample_t        open_batch[$];
  logic           open_dropped;
  median_result_t pending_medians[$];

  // When set, neither side idles; this gives one long stretch at full rate.
  logic steady_flow;

  int unsigned words_sent;
  int unsigned batches_closed;
  int unsigned overflow_batches;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Median of the open batch. An odd count takes the middle value. An even
  // count adds the two middle values at 33 bits and drops the low bit, which is
  // an arithmetic halving that rounds toward minus infinity.
  function automatic sample_t median_of_open_batch();
    int unsigned          n;
    logic signed [SAMPLE_W:0] pair_sum;
    n = open_batch.size();
    if (n == 0) return '0;
    if (n[0]) return open_batch[(n - 1) / 2];
    pair_sum = {open_batch[n/2][SAMPLE_W-1], open_batch[n/2]}
             + {open_batch[n/2-1][SAMPLE_W-1], open_batch[n/2-1]};
    return pair_sum[SAMPLE_W:1];
  endfunction

  // Account for one accepted word: keep it in sorted place or drop it, and on
  // the word marked last queue the result that the batch must give.
  task automatic track_word(input sample_t value, input logic last);
    int unsigned    pos;
    median_result_t res;
    if (open_batch.size() < STORE_DEPTH) begin
      pos = open_batch.size();
      while (pos > 0 && open_batch[pos-1] > value) pos--;
      open_batch.insert(pos, value);
    end else begin
      open_dropped = 1'b1;
    end
    if (last) begin
      res.median   = median_of_open_batch();
      res.count    = OUT_COUNT_W'(open_batch.size());
      res.empty    = (open_batch.size() == 0);
      res.overflow = open_dropped;
      pending_medians.push_back(res);
      batches_closed++;
      if (open_dropped) overflow_batches++;
      open_batch.delete();
      open_dropped = 1'b0;
    end
  endtask

  // Offer one word and hold it until the block takes it. Valid is only lowered
  // when a gap is wanted, so a word that follows straight on never sees valid
  // lowered and raised within the same step.
  task automatic send_word(input sample_t value, input logic last);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= value;
    in_if.last_sample <= last;
    do @(posedge clk_i); while (!in_if.ready);
    track_word(value, last);
    words_sent++;
  endtask

  // Send a whole batch, marking its final value as last.
  task automatic send_batch(input sample_t vals[$]);
    foreach (vals[i]) send_word(vals[i], (i == vals.size() - 1));
  endtask

  // A value drawn so that extremes, near-extremes and small clustered values
  // (which give many duplicates) all turn up alongside plain random words.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      5, 6:    return sample_t'($signed($urandom_range(15)) - 8);
      7:       return SAMPLE_MAX - sample_t'($urandom_range(3));
      8:       return SAMPLE_MIN + sample_t'($urandom_range(3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Single values and pairs at the ends of the range. The pair of both
  // extremes sums to minus one, which must halve to minus one.
  task automatic test_extreme_values();
    sample_t b[$];
    b = '{SAMPLE_MAX};             send_batch(b);
    b = '{SAMPLE_MIN};             send_batch(b);
    b = '{SAMPLE_MAX, SAMPLE_MAX}; send_batch(b);
    b = '{SAMPLE_MIN, SAMPLE_MIN}; send_batch(b);
    b = '{SAMPLE_MAX, SAMPLE_MIN}; send_batch(b);
    b = '{sample_t'(0)};           send_batch(b);
  endtask

  // Even counts whose middle pair has an odd sum, on both sides of zero, so
  // that the rounding toward minus infinity shows.
  task automatic test_even_rounding();
    sample_t b[$];
    b = '{sample_t'(-1), sample_t'(0)}; send_batch(b);
    b = '{sample_t'(4), sample_t'(3)};  send_batch(b);
    b = '{sample_t'(-3), sample_t'(-4)}; send_batch(b);
    b = '{sample_t'(9), sample_t'(-2), sample_t'(100), sample_t'(-50)}; send_batch(b);
  endtask

  // Descending arrival forces every insertion to the bottom of the store, and
  // repeated values exercise ties.
  task automatic test_insert_order();
    sample_t b[$];
    b = '{sample_t'(5), sample_t'(4), sample_t'(3), sample_t'(2), sample_t'(1)};
    send_batch(b);
    b = '{sample_t'(7), sample_t'(-7), sample_t'(7)};
    send_batch(b);
  endtask

  // A batch that fills the store exactly, then batches that run past it: the
  // surplus values, the last one among them, are dropped and flagged.
  task automatic test_store_full();
    sample_t b[$];
    b.delete();
    for (int i = 0; i < STORE_DEPTH; i++) b.push_back(sample_t'(i * 3 - 90));
    send_batch(b);
    b.delete();
    for (int i = 0; i < STORE_DEPTH + 1; i++) b.push_back(pick_sample());
    send_batch(b);
    b.delete();
    for (int i = 0; i < STORE_DEPTH + 2; i++) b.push_back(sample_t'(STORE_DEPTH - i));
    b[STORE_DEPTH + 1] = SAMPLE_MIN;
    send_batch(b);
  endtask

  // Random batches, mostly short, some long and a few that overflow. A middle
  // section runs with no idling on either side.
  task automatic test_random_batches();
    int unsigned start_words;
    int unsigned len;
    int unsigned pick;
    sample_t     b[$];
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      steady_flow = (words_sent - start_words >= 300) && (words_sent - start_words < 450);
      pick = $urandom_range(99);
      if (pick < 78)      len = $urandom_range(12, 1);
      else if (pick < 92) len = $urandom_range(48, 13);
      else                len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 4);
      b.delete();
      for (int i = 0; i < len; i++) b.push_back(pick_sample());
      send_batch(b);
    end
    steady_flow = 1'b0;
  endtask

  // Result ready: idles at random, except during the steady stretch.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: every word taken on the output is compared, field by
  // field, with the oldest queued expectation.
  initial begin
    median_result_t want;
    logic           bad;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_medians.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result word: median %0d count %0d empty %0b overflow %0b",
                     out_if.median_value, out_if.sample_count, out_if.batch_empty,
                     out_if.batch_overflow);
        end else begin
          want = pending_medians.pop_front();
          bad  = (out_if.median_value   !== want.median)
              || (out_if.sample_count   !== want.count)
              || (out_if.batch_empty    !== want.empty)
              || (out_if.batch_overflow !== want.overflow);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("result %0d mismatch: expected median %0d count %0d empty %0b overflow %0b",
                       results_seen, want.median, want.count, want.empty, want.overflow);
              $display("  got median %0d count %0d empty %0b overflow %0b",
                       out_if.median_value, out_if.sample_count, out_if.batch_empty,
                       out_if.batch_overflow);
            end
          end
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_medians.size());
    $display("batch_median_select_test failed");
    $finish;
  end

  initial begin
    words_sent       = 0;
    batches_closed   = 0;
    overflow_batches = 0;
    results_seen     = 0;
    mismatch_count   = 0;
    open_dropped     = 1'b0;
    steady_flow      = 1'b0;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.last_sample <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_values();
    test_even_rounding();
    test_insert_order();
    test_store_full();
    test_random_batches();

    in_if.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d sample words in %0d batches, %0d of them past the store size.",
             words_sent, batches_closed, overflow_batches);
    $display("Checked %0d result words; %0d mismatched, %0d still outstanding.",
             results_seen, mismatch_count, pending_medians.size());
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("batch_median_select_test passed");
    end else begin
      $display("batch_median_select_test failed");
    end
    $finish;
  end

endmodule
